/* src/min_variance_line_finder_macros.svh */
// Assertion helpers; clk and rst are taken from the enclosing module.
`ifndef MIN_VARIANCE_LINE_FINDER_MACROS_SVH
`define MIN_VARIANCE_LINE_FINDER_MACROS_SVH

`ifndef SYNTH
`define MVLF_ASSERT_IMPLY(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("implication check failed");
`define MVLF_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("next-cycle check failed");
`else
`define MVLF_ASSERT_IMPLY(label, pre, post)
`define MVLF_ASSERT_NEXT(label, pre, post)
`endif

`endif

/* src/mvlf_pkg.sv */
package mvlf_pkg;

  localparam int MAX_LINE_LENGTH_DEF = 255;
  localparam int QUEUE_DEPTH_DEF     = 4;

  localparam logic [7:0]  LINE_LENGTH_RESET = 8'd80;
  localparam logic [23:0] LINE_MAX          = 24'hFFFFFF;
  localparam logic [29:0] VAR_MAX           = 30'h3FFFFFFF;

  localparam int CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] REG_LINE_LENGTH = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_REGION_BASE = 1'b1;

  typedef struct packed {
    logic [7:0] sample;
    logic       last;
  } byte_item_t;

  typedef struct packed {
    logic [23:0] best_line;
    logic [31:0] best_first;
    logic [31:0] best_final;
    logic [14:0] best_std_dev;
    logic [29:0] best_variance;
    logic [23:0] line_total;
  } result_t;

  // One closed line, handed from the front to the back.
  typedef struct packed {
    logic [7:0]  n;
    logic [15:0] sum;
    logic [23:0] sumsq;
    logic [23:0] line_idx;
    logic [31:0] first;
    logic [31:0] final_ofs;
    logic [23:0] total;
    logic        last;
  } line_rec_t;

endpackage

/* src/min_variance_line_finder.sv */
// Channel    Dir  Payload                  Moves
// byte       in   mvlf_pkg::byte_item_t    one region byte per request
// result     out  mvlf_pkg::result_t       one request per region, on its last byte
// cfg        in   cfg_index, cfg_data      one register write per request
//
// The front takes one byte per cycle while the line queue has room.
// The back takes one closed line at a time through multiply, setup, 30-step divide,
// and compare; a region's last line adds 15 root steps and one result request.
// Lines shorter than about 34 bytes fill the queue and then stall the byte side.
// A result waiting on result_ready holds the back in idle; bytes still queue.
// Synchronous reset clears all control state; line_length returns to 80,
// region_base to 0.
`include "min_variance_line_finder_macros.svh"

module min_variance_line_finder #(
  parameter int MAX_LINE_LENGTH = mvlf_pkg::MAX_LINE_LENGTH_DEF,
  parameter int QUEUE_DEPTH     = mvlf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             byte_valid,
  output logic                             byte_ready,
  input  mvlf_pkg::byte_item_t             byte_data,
  output logic                             result_valid,
  input  logic                             result_ready,
  output mvlf_pkg::result_t                result_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [mvlf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0]                      cfg_data
);

  logic                q_push;
  logic                q_pop;
  logic                q_full;
  logic                q_empty;
  mvlf_pkg::line_rec_t q_rec;
  mvlf_pkg::line_rec_t q_head;

  assign cfg_ready = 1'b1;

  mvlf_front #(
    .MAX_LINE_LENGTH(MAX_LINE_LENGTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .byte_valid(byte_valid),
    .byte_ready(byte_ready),
    .byte_data (byte_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_push    (q_push),
    .q_rec     (q_rec),
    .q_full    (q_full)
  );

  mvlf_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .push_rec(q_rec),
    .full    (q_full),
    .pop     (q_pop),
    .head    (q_head),
    .empty   (q_empty)
  );

  mvlf_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result_data (result_data)
  );

  `MVLF_ASSERT_IMPLY(a_no_overflow, q_push, !q_full)
  `MVLF_ASSERT_IMPLY(a_no_underflow, q_pop, !q_empty)
  `MVLF_ASSERT_IMPLY(a_last_closes, byte_valid && byte_ready && byte_data.last, q_push)
  `MVLF_ASSERT_NEXT(a_push_lands, q_push && !q_pop, !q_empty)

endmodule

/* src/mvlf_front.sv */
module mvlf_front #(
  parameter int MAX_LINE_LENGTH = mvlf_pkg::MAX_LINE_LENGTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             byte_valid,
  output logic                             byte_ready,
  input  mvlf_pkg::byte_item_t             byte_data,
  input  logic                             cfg_valid,
  input  logic [mvlf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0]                      cfg_data,
  output logic                             q_push,
  output mvlf_pkg::line_rec_t              q_rec,
  input  logic                             q_full
);

  localparam logic [7:0] LEN_CAP = 8'(MAX_LINE_LENGTH);

  logic [7:0]  line_length;
  logic [31:0] region_base;

  logic [7:0]  position_in_line;
  logic [15:0] line_sum;
  logic [23:0] line_square_sum;
  logic [31:0] byte_offset;
  logic [23:0] line_number;
  logic [31:0] line_first_offset;

  logic [7:0]  len_eff;
  logic [31:0] here;
  logic [7:0]  pos_inc;
  logic [23:0] line_inc;
  logic        close;
  logic        accept;

  always_comb begin
    if (line_length == 8'd0) begin
      len_eff = 8'd1;
    end else if (line_length > LEN_CAP) begin
      len_eff = LEN_CAP;
    end else begin
      len_eff = line_length;
    end
    here     = region_base + byte_offset;
    pos_inc  = position_in_line + 8'd1;
    line_inc = (line_number == mvlf_pkg::LINE_MAX) ? line_number : line_number + 24'd1;
    close    = (pos_inc >= len_eff) || byte_data.last;
  end

  assign byte_ready = !q_full;
  assign accept     = byte_valid && byte_ready;
  assign q_push     = accept && close;

  always_comb begin
    q_rec.n         = pos_inc;
    q_rec.sum       = line_sum + {8'd0, byte_data.sample};
    q_rec.sumsq     = line_square_sum +
                      {8'd0, 16'(byte_data.sample) * 16'(byte_data.sample)};
    q_rec.line_idx  = line_number;
    q_rec.first     = (position_in_line == 8'd0) ? here : line_first_offset;
    q_rec.final_ofs = here;
    q_rec.total     = line_inc;
    q_rec.last      = byte_data.last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_length <= mvlf_pkg::LINE_LENGTH_RESET;
      region_base <= 32'd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        mvlf_pkg::REG_LINE_LENGTH: line_length <= cfg_data[7:0];
        mvlf_pkg::REG_REGION_BASE: region_base <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position_in_line  <= 8'd0;
      line_sum          <= 16'd0;
      line_square_sum   <= 24'd0;
      byte_offset       <= 32'd0;
      line_number       <= 24'd0;
      line_first_offset <= 32'd0;
    end else if (accept) begin
      if (byte_data.last) begin
        // end of region: drop all region state
        position_in_line  <= 8'd0;
        line_sum          <= 16'd0;
        line_square_sum   <= 24'd0;
        byte_offset       <= 32'd0;
        line_number       <= 24'd0;
        line_first_offset <= 32'd0;
      end else begin
        byte_offset       <= byte_offset + 32'd1;
        line_first_offset <= q_rec.first;
        if (close) begin
          position_in_line <= 8'd0;
          line_sum         <= 16'd0;
          line_square_sum  <= 24'd0;
          line_number      <= line_inc;
        end else begin
          position_in_line <= pos_inc;
          line_sum         <= q_rec.sum;
          line_square_sum  <= q_rec.sumsq;
        end
      end
    end
  end

endmodule

/* src/mvlf_queue.sv */
module mvlf_queue #(
  parameter int DEPTH = mvlf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  mvlf_pkg::line_rec_t push_rec,
  output logic                full,
  input  logic                pop,
  output mvlf_pkg::line_rec_t head,
  output logic                empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  mvlf_pkg::line_rec_t slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

/* src/mvlf_back.sv */
module mvlf_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_empty,
  input  mvlf_pkg::line_rec_t q_head,
  output logic                q_pop,
  output logic                result_valid,
  input  logic                result_ready,
  output mvlf_pkg::result_t   result_data
);

  localparam int DIV_STEPS  = 30;
  localparam int ROOT_STEPS = 15;
  localparam int CNT_W      = $clog2(DIV_STEPS);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_MUL    = 6'b000010,
    ST_PREP   = 6'b000100,
    ST_DIVIDE = 6'b001000,
    ST_UPDATE = 6'b010000,
    ST_ROOT   = 6'b100000
  } back_state_t;

  back_state_t state;
  logic        out_full;

  mvlf_pkg::line_rec_t rec;
  logic [31:0] prod_a;
  logic [31:0] prod_b;
  logic [15:0] div_d;
  logic        div_sat;
  logic [15:0] div_rem;
  logic [29:0] div_dvd;
  logic [29:0] div_quot;
  logic [CNT_W-1:0] step_cnt;

  logic [29:0] root_val;
  logic [16:0] root_rem;
  logic [14:0] root;

  logic [29:0] lowest_variance;
  logic [23:0] lowest_line;
  logic [31:0] lowest_first;
  logic [31:0] lowest_final;
  logic        have_lowest;

  logic [31:0] num;
  logic [16:0] div_rem_s;
  logic        div_take;
  logic [29:0] var_val;
  logic        take;
  logic [18:0] root_rem_s;
  logic [18:0] root_trial;
  logic        root_take;
  logic [14:0] root_next;

  always_comb begin
    num        = prod_a - prod_b;
    div_rem_s  = {div_rem, div_dvd[29]};
    div_take   = div_rem_s >= {1'b0, div_d};
    var_val    = div_sat ? mvlf_pkg::VAR_MAX : div_quot;
    take       = !have_lowest || (var_val < lowest_variance);
    root_rem_s = {root_rem, root_val[29:28]};
    root_trial = {2'b00, root, 2'b01};
    root_take  = root_rem_s >= root_trial;
    root_next  = {root[13:0], root_take};
  end

  assign q_pop        = (state == ST_IDLE) && !out_full && !q_empty;
  assign result_valid = out_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      out_full        <= 1'b0;
      have_lowest     <= 1'b0;
      lowest_variance <= 30'd0;
      lowest_line     <= 24'd0;
      lowest_first    <= 32'd0;
      lowest_final    <= 32'd0;
      step_cnt        <= '0;
    end else begin
      if (out_full && result_ready) begin
        out_full <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (q_pop) begin
            rec   <= q_head;
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod_a <= {24'd0, rec.n} * {8'd0, rec.sumsq};
          prod_b <= {16'd0, rec.sum} * {16'd0, rec.sum};
          div_d  <= {8'd0, rec.n} * {8'd0, rec.n};
          state  <= ST_PREP;
        end
        ST_PREP: begin
          // quotient overflows 30 bits exactly when num >= d * 2^14
          div_sat  <= num >= {2'b00, div_d, 14'd0};
          div_rem  <= num[29:14];
          div_dvd  <= {num[13:0], 16'd0};
          div_quot <= 30'd0;
          step_cnt <= '0;
          state    <= ST_DIVIDE;
        end
        ST_DIVIDE: begin
          div_rem  <= div_take ? 16'(div_rem_s - {1'b0, div_d}) : div_rem_s[15:0];
          div_dvd  <= {div_dvd[28:0], 1'b0};
          div_quot <= {div_quot[28:0], div_take};
          step_cnt <= step_cnt + CNT_W'(1);
          if (step_cnt == CNT_W'(DIV_STEPS - 1)) begin
            state <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          if (take) begin
            have_lowest     <= 1'b1;
            lowest_variance <= var_val;
            lowest_line     <= rec.line_idx;
            lowest_first    <= rec.first;
            lowest_final    <= rec.final_ofs;
          end
          root_val <= take ? var_val : lowest_variance;
          root_rem <= 17'd0;
          root     <= 15'd0;
          step_cnt <= '0;
          state    <= rec.last ? ST_ROOT : ST_IDLE;
        end
        ST_ROOT: begin
          root_rem <= root_take ? 17'(root_rem_s - root_trial) : root_rem_s[16:0];
          root_val <= {root_val[27:0], 2'b00};
          root     <= root_next;
          step_cnt <= step_cnt + CNT_W'(1);
          if (step_cnt == CNT_W'(ROOT_STEPS - 1)) begin
            result_data.best_line     <= lowest_line;
            result_data.best_first    <= lowest_first;
            result_data.best_final    <= lowest_final;
            result_data.best_std_dev  <= root_next;
            result_data.best_variance <= lowest_variance;
            result_data.line_total    <= rec.total;
            out_full                  <= 1'b1;
            // region done: drop the kept line
            have_lowest     <= 1'b0;
            lowest_variance <= 30'd0;
            lowest_line     <= 24'd0;
            lowest_first    <= 32'd0;
            lowest_final    <= 32'd0;
            state           <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
